// File: design/u8san_pkg.sv
// Shared types and constants for the UTF-8 sanitizer.
package u8san_pkg;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw = $clog2(QDepth);
	localparam int unsigned MaxOut = 4;
	localparam int unsigned HeldDepth = 3;

	localparam logic [7:0] RejectByte = 8'h3F;

	// One accepted byte's worth of results.
	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [2:0]             cnt;
		logic                   fin;
	} grp_t;

	typedef struct packed {
		logic push;
		grp_t grp;
	} push_t;

	typedef struct packed {
		logic valid;
		grp_t grp;
	} head_t;

endpackage

// File: design/u8san_front.sv
// Front end: decodes each byte against the held sequence and builds its result group.
module u8san_front
	import u8san_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic        string_end,
	output push_t       push
);

	logic [HeldDepth-1:0][7:0] held_q;
	logic [1:0]                hcnt_q;
	logic [2:0]                elen_q;

	logic [HeldDepth-1:0][7:0] held_n;
	logic [1:0]                hcnt_n;
	logic [2:0]                elen_n;
	grp_t                      grp;
	logic [2:0]                n;
	logic [2:0]                flen;
	logic                      is_cont;

	always_comb begin
		if (!in_byte[7])
			flen = 3'd1;
		else if (in_byte[7:5] == 3'b110)
			flen = 3'd2;
		else if (in_byte[7:4] == 4'b1110)
			flen = 3'd3;
		else if (in_byte[7:3] == 5'b11110)
			flen = 3'd4;
		else
			flen = 3'd0;
	end

	assign is_cont = (in_byte[7:6] == 2'b10);

	always_comb begin
		held_n = held_q;
		hcnt_n = hcnt_q;
		elen_n = elen_q;
		grp = '0;
		n = 3'd0;
		if (hcnt_q != 2'd0 && is_cont) begin
			if (({1'b0, hcnt_q} + 3'd1) >= elen_q) begin
				for (int j = 0; j < HeldDepth; j++) begin
					if (j < int'(hcnt_q)) begin
						grp.bytes[n[1:0]] = held_q[2'(j)];
						n = n + 3'd1;
					end
				end
				grp.bytes[n[1:0]] = in_byte;
				n = n + 3'd1;
				hcnt_n = 2'd0;
				elen_n = 3'd0;
			end else begin
				if (hcnt_q < 2'(HeldDepth))
					held_n[hcnt_q] = in_byte;
				hcnt_n = hcnt_q + 2'd1;
			end
		end else begin
			for (int j = 0; j < HeldDepth; j++) begin
				if (j < int'(hcnt_q)) begin
					grp.bytes[n[1:0]] = RejectByte;
					n = n + 3'd1;
				end
			end
			hcnt_n = 2'd0;
			elen_n = 3'd0;
			case (flen)
				3'd1: begin
					grp.bytes[n[1:0]] = in_byte;
					n = n + 3'd1;
				end
				3'd0: begin
					grp.bytes[n[1:0]] = RejectByte;
					n = n + 3'd1;
				end
				default: begin
					held_n[0] = in_byte;
					hcnt_n = 2'd1;
					elen_n = flen;
				end
			endcase
		end
		if (string_end) begin
			for (int j = 0; j < HeldDepth; j++) begin
				if (j < int'(hcnt_n) && n < 3'(MaxOut)) begin
					grp.bytes[n[1:0]] = RejectByte;
					n = n + 3'd1;
				end
			end
			hcnt_n = 2'd0;
			elen_n = 3'd0;
		end
		grp.cnt = n;
		grp.fin = string_end;
	end

	assign push.push = accept && (n != 3'd0);
	assign push.grp  = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= 2'd0;
			elen_q <= 3'd0;
		end else if (accept) begin
			hcnt_q <= hcnt_n;
			elen_q <= elen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			held_q <= held_n;
	end

endmodule

// File: design/u8san_queue.sv
// Short group queue between front and back end.
module u8san_queue
	import u8san_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	input  logic        pop,
	output head_t       head,
	output logic        full,
	output logic [QAw:0] level
);

	grp_t           mem_q [QDepth];
	logic [QAw-1:0] wr_q;
	logic [QAw-1:0] rd_q;
	logic [QAw:0]   cnt_q;
	logic           do_pop;

	assign do_pop = pop && (cnt_q != '0);
	assign full   = (cnt_q == (QAw+1)'(QDepth));
	assign level  = cnt_q;

	assign head.valid = (cnt_q != '0);
	assign head.grp   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.push)
				wr_q <= wr_q + QAw'(1);
			if (do_pop)
				rd_q <= rd_q + QAw'(1);
			case ({push.push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QAw+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAw+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.push)
			mem_q[wr_q] <= push.grp;
	end

endmodule

// File: design/u8san_back.sv
// Back end: serializes each group into output beats through an output register.
module u8san_back
	import u8san_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  head_t      head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tuser
);

	logic [1:0] idx_q;
	logic       load;
	logic       last;

	assign load = head.valid && (!m_tvalid || m_tready);
	assign last = ({1'b0, idx_q} + 3'd1) == head.grp.cnt;
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 2'd0;
			m_tvalid <= 1'b0;
		end else begin
			if (load)
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			if (load)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= head.grp.bytes[idx_q];
			m_tuser <= last;
			m_tlast <= last && head.grp.fin;
		end
	end

endmodule

// File: design/utf8_sanitizer.sv
// Top level of the UTF-8 sanitizer.
// Path: result groups pass from the front end through the queue to the back end's output register.
// Throughput: one input byte per cycle while the queue is not full; the back end sends one beat
// per cycle while m_tready allows, and a group stays at the queue head until its last beat loads;
// a four-group queue absorbs this and s_tready drops only while the queue is full.
// Reset: arst_n clears held count, form length, queue pointers, beat index and output valid.
module utf8_sanitizer
	import u8san_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       s_tlast,  // string_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast,  // output_end
	output logic       m_tuser   // [0] run_last
);

	push_t        push;
	head_t        head;
	logic         pop;
	logic         full;
	logic [QAw:0] level;
	logic         accept;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	u8san_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (s_tdata),
		.string_end (s_tlast),
		.push       (push)
	);

	u8san_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.level  (level)
	);

	u8san_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	a_end_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |-> push.push)
		else $error("string end produced no results");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("output end beat not marked as run last");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= (QAw+1)'(QDepth))
		else $error("queue level out of range");

	a_group_count: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (head.grp.cnt != 3'd0 && head.grp.cnt <= 3'(MaxOut)))
		else $error("queued group with bad count");

endmodule
